>>> rtl/grid_triangle_strip_indexer_defines.svh
// assertion macros for the grid triangle strip indexer
`ifndef GRID_TRIANGLE_STRIP_INDEXER_DEFINES_SVH
`define GRID_TRIANGLE_STRIP_INDEXER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GTSI_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gtsi same-cycle check failed");

// next-cycle implication, checked outside reset
`define GTSI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gtsi next-cycle check failed");

`endif

>>> rtl/gtsi_pkg.sv
// shared types and constants of the grid triangle strip indexer
`default_nettype none

package gtsi_pkg;

    localparam int unsigned MAX_SIDE_VERTS = 256;
    localparam int unsigned SIDE_W         = 9;
    localparam int unsigned ROW_W          = 8;
    localparam int unsigned INDEX_W        = 16;
    localparam int unsigned PHASE_W        = 3;

    typedef logic [SIDE_W-1:0]  side_t;
    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [PHASE_W-1:0] phase_t;

    // phase codes
    localparam phase_t PH_FIRST  = 3'd0;
    localparam phase_t PH_SECOND = 3'd1;
    localparam phase_t PH_JOIN0  = 3'd2;
    localparam phase_t PH_JOIN1  = 3'd3;
    localparam phase_t PH_JOIN2  = 3'd4;
    localparam phase_t PH_JOIN3  = 3'd5;

    // register indexes
    localparam logic CFG_X_VERTS = 1'b0;
    localparam logic CFG_Y_VERTS = 1'b1;

    localparam side_t SIDE_RESET = 9'd17;
    localparam side_t SIDE_MIN   = 9'd2;
    localparam side_t SIDE_MAX   = side_t'(MAX_SIDE_VERTS);

endpackage

`default_nettype wire

>>> rtl/grid_triangle_strip_indexer.sv
// grid triangle strip indexer: serpentine strip over a vertex grid with degenerate row joins
// the index of an accepted word is registered and shows at m_tdata from the next cycle
// one word per cycle unless m_tready stalls; row multiply, position update share one stage
// s_tready stays high while the output register is empty or being drained
// reset (aresetn low, synchronous): strip position to its first index, output empty,
// x_verts and y_verts back to 17
`default_nettype none
`include "grid_triangle_strip_indexer_defines.svh"

module grid_triangle_strip_indexer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    // index channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] vertex_index
    output logic [0:0]       m_tuser,   // [0] is_join
    output logic             m_tlast    // final index of the strip
);

    // configuration registers, hold the raw written bits
    gtsi_pkg::side_t x_verts_reg;
    gtsi_pkg::side_t y_verts_reg;

    // strip position
    gtsi_pkg::row_t   row_reg,   row_next;
    gtsi_pkg::side_t  col_reg,   col_next;
    gtsi_pkg::phase_t phase_reg, phase_next;

    // output register
    logic                              m_valid_reg;
    logic [gtsi_pkg::INDEX_W-1:0]      index_reg, index_next;
    logic                              join_reg,  join_next;
    logic                              last_reg,  last_next;

    logic s_fire;

    // clamped grid shape
    gtsi_pkg::side_t x_side;
    gtsi_pkg::side_t y_side;
    gtsi_pkg::side_t ix;        // last column
    gtsi_pkg::side_t p_rows;    // quad rows, 1..255

    // position after restart and sanity check
    logic             go_start;
    gtsi_pkg::row_t   cur_row;
    gtsi_pkg::side_t  cur_col;
    gtsi_pkg::phase_t cur_phase;
    gtsi_pkg::side_t  row_p1;
    gtsi_pkg::side_t  col_rev;
    logic             odd_row;

    // index datapath
    gtsi_pkg::side_t row_sel;
    gtsi_pkg::side_t col_sel;
    logic [2*gtsi_pkg::SIDE_W-1:0] row_base;
    logic [2*gtsi_pkg::SIDE_W-1:0] index_full;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = index_reg;
    assign m_tuser[0] = join_reg;
    assign m_tlast    = last_reg;

    // out-of-range sides are used as the nearest legal value
    always_comb begin
        if (x_verts_reg < gtsi_pkg::SIDE_MIN) begin
            x_side = gtsi_pkg::SIDE_MIN;
        end else if (x_verts_reg > gtsi_pkg::SIDE_MAX) begin
            x_side = gtsi_pkg::SIDE_MAX;
        end else begin
            x_side = x_verts_reg;
        end
        if (y_verts_reg < gtsi_pkg::SIDE_MIN) begin
            y_side = gtsi_pkg::SIDE_MIN;
        end else if (y_verts_reg > gtsi_pkg::SIDE_MAX) begin
            y_side = gtsi_pkg::SIDE_MAX;
        end else begin
            y_side = y_verts_reg;
        end
        ix     = x_side - 9'd1;
        p_rows = y_side - 9'd1;
    end

    // restart on request, on an unknown phase or on a position outside the current grid
    always_comb begin
        go_start = s_tdata[0]
                || (phase_reg > gtsi_pkg::PH_JOIN3)
                || ({1'b0, row_reg} >= p_rows)
                || ((phase_reg <= gtsi_pkg::PH_SECOND)
                    && ((col_reg >= x_side) || ((row_reg != '0) && (col_reg == '0))))
                || ((phase_reg >= gtsi_pkg::PH_JOIN0)
                    && (({1'b0, row_reg} + 9'd1) >= p_rows));
        if (go_start) begin
            cur_row   = '0;
            cur_col   = '0;
            cur_phase = gtsi_pkg::PH_FIRST;
        end else begin
            cur_row   = row_reg;
            cur_col   = col_reg;
            cur_phase = phase_reg;
        end
        row_p1  = {1'b0, cur_row} + 9'd1;
        col_rev = ix - cur_col;
        odd_row = cur_row[0];
    end

    // pick the grid row and column of this index
    always_comb begin
        row_sel = {1'b0, cur_row};
        col_sel = cur_col;
        case (cur_phase)
            gtsi_pkg::PH_FIRST: begin
                row_sel = odd_row ? {1'b0, cur_row} : row_p1;
                col_sel = odd_row ? col_rev : cur_col;
            end
            gtsi_pkg::PH_SECOND: begin
                row_sel = odd_row ? row_p1 : {1'b0, cur_row};
                col_sel = odd_row ? col_rev : cur_col;
            end
            gtsi_pkg::PH_JOIN3: begin
                // even rows step down to the next row here
                row_sel = odd_row ? row_p1 : row_p1 + 9'd1;
                col_sel = odd_row ? '0 : ix;
            end
            gtsi_pkg::PH_JOIN2: begin
                // odd rows step down one entry earlier
                row_sel = odd_row ? row_p1 + 9'd1 : row_p1;
                col_sel = odd_row ? '0 : ix;
            end
            default: begin
                row_sel = row_p1;
                col_sel = odd_row ? '0 : ix;
            end
        endcase
        row_base   = row_sel * x_side;
        index_full = row_base + {9'd0, col_sel};
    end

    // flags and position advance
    always_comb begin
        index_next = index_full[gtsi_pkg::INDEX_W-1:0];
        join_next  = (cur_phase >= gtsi_pkg::PH_JOIN0);
        last_next  = (cur_phase == gtsi_pkg::PH_SECOND) && (cur_col == ix)
                  && (row_p1 == p_rows);

        row_next   = cur_row;
        col_next   = cur_col;
        phase_next = cur_phase;
        case (cur_phase)
            gtsi_pkg::PH_FIRST: begin
                phase_next = gtsi_pkg::PH_SECOND;
            end
            gtsi_pkg::PH_SECOND: begin
                if (cur_col < ix) begin
                    col_next   = cur_col + 9'd1;
                    phase_next = gtsi_pkg::PH_FIRST;
                end else if (row_p1 < p_rows) begin
                    phase_next = gtsi_pkg::PH_JOIN0;
                end else begin
                    // end of strip, wrap to the first index
                    row_next   = '0;
                    col_next   = '0;
                    phase_next = gtsi_pkg::PH_FIRST;
                end
            end
            gtsi_pkg::PH_JOIN3: begin
                // later rows skip their shared first column
                row_next   = row_p1[gtsi_pkg::ROW_W-1:0];
                col_next   = 9'd1;
                phase_next = gtsi_pkg::PH_FIRST;
            end
            default: begin
                phase_next = cur_phase + 3'd1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_verts_reg <= gtsi_pkg::SIDE_RESET;
            y_verts_reg <= gtsi_pkg::SIDE_RESET;
            row_reg     <= '0;
            col_reg     <= '0;
            phase_reg   <= gtsi_pkg::PH_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    gtsi_pkg::CFG_X_VERTS: x_verts_reg <= cfg_data;
                    gtsi_pkg::CFG_Y_VERTS: y_verts_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_fire) begin
                row_reg     <= row_next;
                col_reg     <= col_next;
                phase_reg   <= phase_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            index_reg <= index_next;
            join_reg  <= join_next;
            last_reg  <= last_next;
        end
    end

    // the strip never ends on a join entry
    `GTSI_ASSERT_NOW(a_last_not_join, aclk, aresetn, m_valid_reg && last_reg, !join_reg)
    // after the final index the position is back at the first index
    `GTSI_ASSERT_NEXT(a_wrap_to_start, aclk, aresetn, s_fire && last_next,
        (row_reg == '0) && (col_reg == '0) && (phase_reg == gtsi_pkg::PH_FIRST))
    // a restart always delivers the first pair half, never a join
    `GTSI_ASSERT_NEXT(a_restart_no_join, aclk, aresetn, s_fire && s_tdata[0],
        m_valid_reg && !join_reg && (phase_reg == gtsi_pkg::PH_SECOND))

endmodule

`default_nettype wire

>>> tb/grid_triangle_strip_indexer_tb.sv
// self-checking testbench for the grid triangle strip indexer: predicts every index word
`default_nettype none

module grid_triangle_strip_indexer_tb;

    // cycles without any accepted word before the run is declared hung
    localparam int unsigned STALL_LIMIT  = 1000;
    // random request words to send once the directed tests are done
    localparam int unsigned RANDOM_WORDS = 780;

    typedef struct packed {
        logic [gtsi_pkg::INDEX_W-1:0] vertex;
        logic                         is_join;
        logic                         is_last;
    } strip_word_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic                cfg_index;
    logic [8:0]          cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;   // [0] restart, [7:1] zero
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;   // [15:0] vertex_index
    logic [0:0]          m_tuser;   // [0] is_join
    logic                m_tlast;

    // predicted strip position and the register copies it depends on
    gtsi_pkg::side_t  x_reg;
    gtsi_pkg::side_t  y_reg;
    gtsi_pkg::row_t   strip_row;
    gtsi_pkg::side_t  strip_col;
    gtsi_pkg::phase_t strip_ph;

    strip_word_t expected_words[$];
    int unsigned mismatches;
    int unsigned stall_cycles;
    bit          no_stall;      // when set neither side idles

    grid_triangle_strip_indexer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // strip predictor
    // ---------------------------------------------------------------

    // out-of-range register values are pinned to the legal side range
    function automatic int unsigned side_clamp(input gtsi_pkg::side_t raw);
        if (raw < gtsi_pkg::SIDE_MIN) return gtsi_pkg::SIDE_MIN;
        if (raw > gtsi_pkg::SIDE_MAX) return gtsi_pkg::SIDE_MAX;
        return raw;
    endfunction

    function automatic void rewind_strip();
        strip_row = '0;
        strip_col = '0;
        strip_ph  = gtsi_pkg::PH_FIRST;
    endfunction

    // index word the block must produce for one request, then step the position
    function automatic strip_word_t next_strip_word(input bit restart);
        strip_word_t w;
        int unsigned cols;
        int unsigned quad_rows;
        int unsigned ix;
        int unsigned j;
        int unsigned c;
        int unsigned vtx;
        bit          odd_row;
        cols      = side_clamp(x_reg);
        quad_rows = side_clamp(y_reg) - 1;
        ix        = cols - 1;
        if (restart) rewind_strip();
        // a position that does not fit the current grid falls back to the start
        if (strip_ph > gtsi_pkg::PH_JOIN3 || strip_row >= quad_rows ||
            (strip_ph < gtsi_pkg::PH_JOIN0 &&
             (strip_col >= cols || (strip_row != 0 && strip_col == 0))) ||
            (strip_ph >= gtsi_pkg::PH_JOIN0 && strip_row + 1 >= quad_rows))
            rewind_strip();
        j       = strip_row;
        c       = strip_col;
        odd_row = strip_row[0];
        case (strip_ph)
            gtsi_pkg::PH_FIRST:
                vtx = odd_row ? j * cols + (ix - c) : (j + 1) * cols + c;
            gtsi_pkg::PH_SECOND:
                vtx = odd_row ? (j + 1) * cols + (ix - c) : j * cols + c;
            // odd rows join on the left edge, even rows on the right edge
            gtsi_pkg::PH_JOIN2:
                vtx = odd_row ? (j + 2) * cols : (j + 1) * cols + ix;
            gtsi_pkg::PH_JOIN3:
                vtx = odd_row ? (j + 1) * cols : (j + 2) * cols + ix;
            default:
                vtx = odd_row ? (j + 1) * cols : (j + 1) * cols + ix;
        endcase
        w.vertex  = vtx[gtsi_pkg::INDEX_W-1:0];
        w.is_join = (strip_ph >= gtsi_pkg::PH_JOIN0);
        w.is_last = (strip_ph == gtsi_pkg::PH_SECOND) && (c == ix) && (j + 1 == quad_rows);
        case (strip_ph)
            gtsi_pkg::PH_FIRST: strip_ph = gtsi_pkg::PH_SECOND;
            gtsi_pkg::PH_SECOND: begin
                if (c < ix) begin
                    strip_col = gtsi_pkg::side_t'(c + 1);
                    strip_ph  = gtsi_pkg::PH_FIRST;
                end else if (j + 1 < quad_rows) begin
                    strip_ph = gtsi_pkg::PH_JOIN0;
                end else begin
                    rewind_strip();     // wrap after the final index
                end
            end
            gtsi_pkg::PH_JOIN3: begin
                strip_row = gtsi_pkg::row_t'(j + 1);
                strip_col = gtsi_pkg::side_t'(1);   // shared first column is skipped
                strip_ph  = gtsi_pkg::PH_FIRST;
            end
            default: strip_ph = gtsi_pkg::phase_t'(strip_ph + 1);
        endcase
        return w;
    endfunction

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // starts at a falling edge, returns at the rising edge that takes the word;
    // valid stays high so a following word can go out back to back
    task automatic send_word(input bit restart);
        @(negedge aclk);
        while (!no_stall && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_words.push_back(next_strip_word(restart));
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // sender holds off until every predicted word has come out
    task automatic drain_words();
        stop_sending();
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // only called with the block drained, so the predictor can update at once
    task automatic write_reg(input logic idx, input gtsi_pkg::side_t value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == gtsi_pkg::CFG_X_VERTS) x_reg = value;
        else y_reg = value;
    endtask

    task automatic send_run(input int unsigned count, input int unsigned restart_pct);
        repeat (count) send_word($urandom_range(99) < restart_pct);
    endtask

    // mostly small sides, sometimes the clamped ranges and the largest grid
    function automatic gtsi_pkg::side_t pick_side();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)  return gtsi_pkg::side_t'($urandom_range(1, 0));
        if (r < 14) return gtsi_pkg::side_t'($urandom_range(511, 257));
        if (r < 18) return gtsi_pkg::side_t'($urandom_range(256, 250));
        return gtsi_pkg::side_t'($urandom_range(9, 2));
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // restart handling, the smallest grid with wrap, even and odd row joins
    task automatic test_directed();
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b1);            // restart in the middle of a row
        drain_words();
        // both sides below the minimum: 2x2 grid, four words then wrap
        write_reg(gtsi_pkg::CFG_X_VERTS, 9'd0);
        write_reg(gtsi_pkg::CFG_Y_VERTS, 9'd1);
        send_word(1'b1);
        send_run(4, 0);
        drain_words();
        // 2x4 grid reaches an even-row join and an odd-row join
        write_reg(gtsi_pkg::CFG_X_VERTS, 9'd2);
        write_reg(gtsi_pkg::CFG_Y_VERTS, 9'd4);
        send_word(1'b1);
        send_run(15, 0);
        drain_words();
    endtask

    // sides above the maximum, exactly at it, and shrinking the grid under the
    // held position
    task automatic test_side_extremes();
        write_reg(gtsi_pkg::CFG_X_VERTS, 9'd300);
        write_reg(gtsi_pkg::CFG_Y_VERTS, 9'd0);
        send_word(1'b1);
        send_run(40, 0);
        drain_words();
        write_reg(gtsi_pkg::CFG_X_VERTS, 9'd3);   // held column now off the grid
        send_run(10, 0);
        drain_words();
        write_reg(gtsi_pkg::CFG_X_VERTS, 9'd2);
        write_reg(gtsi_pkg::CFG_Y_VERTS, 9'd511);
        send_run(80, 0);
        drain_words();
        write_reg(gtsi_pkg::CFG_Y_VERTS, 9'd5);   // held row now off the grid
        send_run(20, 0);
        drain_words();
        write_reg(gtsi_pkg::CFG_X_VERTS, 9'd256);
        write_reg(gtsi_pkg::CFG_Y_VERTS, 9'd256);
        send_run(30, 2);
        drain_words();
    endtask

    // long stretch with both sides always ready
    task automatic test_back_to_back();
        no_stall = 1'b1;
        write_reg(gtsi_pkg::CFG_X_VERTS, 9'd5);
        write_reg(gtsi_pkg::CFG_Y_VERTS, 9'd4);
        send_word(1'b1);
        send_run(150, 2);
        drain_words();
        no_stall = 1'b0;
    endtask

    // bursts of mostly continuing requests over random grids; registers change
    // between bursts, often while the strip is mid-way
    task automatic test_random_strips();
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            if ($urandom_range(1)) write_reg(gtsi_pkg::CFG_X_VERTS, pick_side());
            if ($urandom_range(1)) write_reg(gtsi_pkg::CFG_Y_VERTS, pick_side());
            burst = $urandom_range(90, 10);
            send_run(burst, 4);
            sent += burst;
            drain_words();
        end
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    always @(negedge aclk) begin
        m_tready <= no_stall || ($urandom_range(99) >= 16);
    end

    // compare each accepted index word with the oldest prediction
    always @(posedge aclk) begin
        strip_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual index %0d join %0b last %0b",
                         $time, m_tdata, m_tuser[0], m_tlast);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                if (m_tdata !== want.vertex) begin
                    $display("%0t: vertex_index expected %0d actual %0d",
                             $time, want.vertex, m_tdata);
                    mismatches++;
                end
                if (m_tuser[0] !== want.is_join) begin
                    $display("%0t: is_join expected %0b actual %0b (index %0d)",
                             $time, want.is_join, m_tuser[0], want.vertex);
                    mismatches++;
                end
                if (m_tlast !== want.is_last) begin
                    $display("%0t: is_last expected %0b actual %0b (index %0d)",
                             $time, want.is_last, m_tlast, want.vertex);
                    mismatches++;
                end
            end
        end
    end

    // hang detection: any accepted word on either side clears the count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no word accepted for %0d cycles", $time, stall_cycles);
            $display("grid_triangle_strip_indexer_tb failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = gtsi_pkg::CFG_X_VERTS;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        no_stall     = 1'b0;
        mismatches   = 0;
        stall_cycles = 0;
        x_reg        = gtsi_pkg::SIDE_RESET;
        y_reg        = gtsi_pkg::SIDE_RESET;
        rewind_strip();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_side_extremes();
        test_back_to_back();
        test_random_strips();

        drain_words();
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("grid_triangle_strip_indexer_tb passed");
        end else begin
            $display("grid_triangle_strip_indexer_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
